@@ sv/pec_pkg.sv @@
// ---------------------------------------------------------------------------
// pec_pkg: shared constants and types for the pairwise elastic collision block
// Holds the default word and fraction widths and the sequencer state type.
// ---------------------------------------------------------------------------
package pec_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_SQRT  = 9'b000000100,
        ST_VNUM  = 9'b000001000,
        ST_VDIV  = 9'b000010000,
        ST_PNUM  = 9'b000100000,
        ST_PDIV  = 9'b001000000,
        ST_OUT0  = 9'b010000000,
        ST_OUT1  = 9'b100000000
    } state_t;

endpackage

@@ sv/pairwise_elastic_collision.sv @@
// ---------------------------------------------------------------------------
// pairwise_elastic_collision: elastic collision response for two spheres
// Holds a first sphere, then resolves the pair when the second arrives.
// ---------------------------------------------------------------------------
// usage
//   s_ channel carries one sphere per transaction; second = 0 holds it,
//   second = 1 completes the pair (held alone if nothing is held)
//   a held item gives no result and leaves s_ready high
//   a completing item gives two m_ transactions: first sphere (which = 0),
//   then second sphere (which = 1, last = 1)
//   a pair is resolved by squaring and summing the three axis distances,
//   a bit-serial square root, then six velocity and three position
//   divisions on one shared divider; the second result follows once the
//   first has been taken
//   a pair that does not collide skips all divisions
//   zero distance skips the position divisions
//   s_ready is low from a completing transaction until both results are taken
//   the m_ side may stall freely; results wait in the output registers
//   reset clears the held sphere and the sequencer
// ---------------------------------------------------------------------------
module pairwise_elastic_collision #(
    parameter int WORD_WIDTH = pec_pkg::WORD_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [WORD_WIDTH-1:0] s_pos_x,
    input  logic signed [WORD_WIDTH-1:0] s_pos_y,
    input  logic signed [WORD_WIDTH-1:0] s_pos_z,
    input  logic signed [WORD_WIDTH-1:0] s_vel_x,
    input  logic signed [WORD_WIDTH-1:0] s_vel_y,
    input  logic signed [WORD_WIDTH-1:0] s_vel_z,
    input  logic        [WORD_WIDTH-2:0] s_mass,
    input  logic        [WORD_WIDTH-2:0] s_radius,
    input  logic                         s_second,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [WORD_WIDTH-1:0] m_new_pos_x,
    output logic signed [WORD_WIDTH-1:0] m_new_pos_y,
    output logic signed [WORD_WIDTH-1:0] m_new_pos_z,
    output logic signed [WORD_WIDTH-1:0] m_new_vel_x,
    output logic signed [WORD_WIDTH-1:0] m_new_vel_y,
    output logic signed [WORD_WIDTH-1:0] m_new_vel_z,
    output logic                         m_collided,
    output logic                         m_which,
    output logic                         m_last
);

    localparam int W   = WORD_WIDTH;
    localparam int U   = W - 1;
    localparam int BW  = $clog2(W);
    localparam int SQW = 2 * W + 2;
    localparam int NW  = 2 * W + 2;
    localparam int DW  = W + 1;
    localparam logic [NW-1:0] PMAX = NW'({1'b0, {(W-1){1'b1}}});
    localparam logic [NW-1:0] NMAX = PMAX + 1'b1;

    logic signed [W-1:0] p1_reg [3];
    logic signed [W-1:0] v1_reg [3];
    logic signed [W-1:0] p2_reg [3];
    logic signed [W-1:0] v2_reg [3];
    logic signed [W-1:0] nv_reg [6];
    logic        [U-1:0] m1_reg, m2_reg, r1_reg, r2_reg;
    logic                holding_reg;
    logic                col_reg;
    pec_pkg::state_t     state_reg;
    logic [2:0]          idx_reg;
    logic [1:0]          axis_reg;
    logic [SQW-1:0]      sq_reg;
    logic [W-1:0]        root_reg;
    logic [BW-1:0]       bit_reg;
    logic [NW-1:0]       dnum_reg;
    logic [DW-1:0]       dden_reg;
    logic                dneg_reg;
    logic                dstart_reg;
    logic                ddone;
    logic [NW-1:0]       dquot;

    logic                s_fire;
    logic [W:0]          rsum;
    logic                is_b;
    logic signed [W-1:0] va, vb, pa, pb;
    logic        [U-1:0] ma, mb;
    logic signed [W:0]   dax;
    logic [W:0]          dmag;
    logic [W-1:0]        trial;
    logic [2*W-1:0]      trial_sq;
    logic [W-1:0]        vam, vbm;
    logic [U-1:0]        mdiff;
    logic [2*W:0]        t1, t2;
    logic                n1, n2;
    logic [NW-1:0]       vsum;
    logic                vneg;
    logic [NW-1:0]       qsat_mag;
    logic signed [W-1:0] qsat;
    logic [W:0]          overlap;
    logic signed [W+1:0] np1, np2, s_ext;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == pec_pkg::ST_IDLE);
    assign rsum    = {2'b00, r1_reg} + {2'b00, r2_reg};

    // operand selection for the velocity step: even index first sphere
    assign is_b = idx_reg[0];
    assign va   = is_b ? v2_reg[idx_reg[2:1]] : v1_reg[idx_reg[2:1]];
    assign vb   = is_b ? v1_reg[idx_reg[2:1]] : v2_reg[idx_reg[2:1]];
    assign ma   = is_b ? m2_reg : m1_reg;
    assign mb   = is_b ? m1_reg : m2_reg;
    assign pa   = p1_reg[axis_reg];
    assign pb   = p2_reg[axis_reg];

    assign dax  = {pb[W-1], pb} - {pa[W-1], pa};
    assign dmag = dax[W] ? (W+1)'(-dax) : dax;

    assign trial    = root_reg | (W'(1) << bit_reg);
    assign trial_sq = trial * trial;

    assign vam   = va[W-1] ? W'(-va) : W'(va);
    assign vbm   = vb[W-1] ? W'(-vb) : W'(vb);
    assign mdiff = (ma >= mb) ? ma - mb : mb - ma;
    assign t1    = (2*W+1)'(vam * mdiff);
    assign t2    = (2*W+1)'(vbm * {mb, 1'b0});
    assign n1    = va[W-1] ^ (ma < mb);
    assign n2    = vb[W-1];

    always_comb begin
        if (n1 == n2) begin
            vsum = NW'(t1) + NW'(t2);
            vneg = n1;
        end else if (t1 >= t2) begin
            vsum = NW'(t1 - t2);
            vneg = n1;
        end else begin
            vsum = NW'(t2 - t1);
            vneg = n2;
        end
    end

    always_comb begin
        qsat_mag = dquot;
        if (dneg_reg) begin
            if (dquot > NMAX) qsat_mag = NMAX;
            qsat = W'(-qsat_mag);
        end else begin
            if (dquot > PMAX) qsat_mag = PMAX;
            qsat = W'(qsat_mag);
        end
    end

    assign overlap = rsum - {1'b0, root_reg};
    assign s_ext   = dneg_reg ? -(W+2)'(dquot) : (W+2)'(dquot);
    assign np1     = {{2{pa[W-1]}}, pa} - s_ext;
    assign np2     = {{2{pb[W-1]}}, pb} + s_ext;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
        if (v > $signed((W+2)'(PMAX)))
            sat_w = W'(PMAX);
        else if (v < -$signed((W+2)'(NMAX)))
            sat_w = W'(NMAX);
        else
            sat_w = W'(v);
    endfunction

    pec_divider #(
        .NUM_W(NW),
        .DEN_W(DW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (dstart_reg),
        .num    (dnum_reg),
        .den    (dden_reg),
        .done   (ddone),
        .quot   (dquot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pec_pkg::ST_IDLE;
            holding_reg <= 1'b0;
            dstart_reg  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                p1_reg[i] <= '0;
                v1_reg[i] <= '0;
            end
            m1_reg <= '0;
            r1_reg <= '0;
        end else begin
            dstart_reg <= 1'b0;
            case (state_reg)
                pec_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        if (!s_second || !holding_reg) begin
                            p1_reg[0] <= s_pos_x;
                            p1_reg[1] <= s_pos_y;
                            p1_reg[2] <= s_pos_z;
                            v1_reg[0] <= s_vel_x;
                            v1_reg[1] <= s_vel_y;
                            v1_reg[2] <= s_vel_z;
                            m1_reg    <= s_mass;
                            r1_reg    <= s_radius;
                            holding_reg <= 1'b1;
                        end else begin
                            p2_reg[0] <= s_pos_x;
                            p2_reg[1] <= s_pos_y;
                            p2_reg[2] <= s_pos_z;
                            v2_reg[0] <= s_vel_x;
                            v2_reg[1] <= s_vel_y;
                            v2_reg[2] <= s_vel_z;
                            m2_reg    <= s_mass;
                            r2_reg    <= s_radius;
                            holding_reg <= 1'b0;
                            sq_reg    <= '0;
                            axis_reg  <= '0;
                            state_reg <= pec_pkg::ST_SQ;
                        end
                    end
                end
                pec_pkg::ST_SQ: begin
                    sq_reg <= sq_reg + SQW'(dmag * dmag);
                    if (axis_reg == 2'd2) begin
                        root_reg  <= '0;
                        bit_reg   <= BW'(W - 1);
                        state_reg <= pec_pkg::ST_SQRT;
                    end else begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                pec_pkg::ST_SQRT: begin
                    if (SQW'(trial_sq) <= sq_reg)
                        root_reg <= trial;
                    if (bit_reg == '0) begin
                        state_reg <= pec_pkg::ST_VNUM;
                        idx_reg   <= '0;
                    end else begin
                        bit_reg <= bit_reg - 1'b1;
                    end
                end
                pec_pkg::ST_VNUM: begin
                    col_reg <= {1'b0, root_reg} < rsum;
                    if (({1'b0, root_reg} >= rsum) || ({m1_reg} + {m2_reg} == '0
                        && ({1'b0, m1_reg} + {1'b0, m2_reg}) == '0)) begin
                        for (int i = 0; i < 3; i++) begin
                            nv_reg[2*i]   <= v1_reg[i];
                            nv_reg[2*i+1] <= v2_reg[i];
                        end
                        axis_reg  <= '0;
                        state_reg <= ({1'b0, root_reg} < rsum) ? pec_pkg::ST_PNUM
                                                               : pec_pkg::ST_OUT0;
                    end else begin
                        dnum_reg   <= vsum;
                        dden_reg   <= DW'({1'b0, ma} + {1'b0, mb});
                        dneg_reg   <= vneg;
                        dstart_reg <= 1'b1;
                        state_reg  <= pec_pkg::ST_VDIV;
                    end
                end
                pec_pkg::ST_VDIV: begin
                    if (ddone) begin
                        nv_reg[idx_reg] <= qsat;
                        if (idx_reg == 3'd5) begin
                            axis_reg  <= '0;
                            state_reg <= pec_pkg::ST_PNUM;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= pec_pkg::ST_VNUM;
                        end
                    end
                end
                pec_pkg::ST_PNUM: begin
                    if (root_reg == '0) begin
                        state_reg <= pec_pkg::ST_OUT0;
                    end else begin
                        dnum_reg   <= NW'(dmag[W-1:0] * overlap);
                        dden_reg   <= {root_reg, 1'b0};
                        dneg_reg   <= dax[W];
                        dstart_reg <= 1'b1;
                        state_reg  <= pec_pkg::ST_PDIV;
                    end
                end
                pec_pkg::ST_PDIV: begin
                    if (ddone) begin
                        p1_reg[axis_reg] <= sat_w(np1);
                        p2_reg[axis_reg] <= sat_w(np2);
                        if (axis_reg == 2'd2) begin
                            state_reg <= pec_pkg::ST_OUT0;
                        end else begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= pec_pkg::ST_PNUM;
                        end
                    end
                end
                pec_pkg::ST_OUT0: begin
                    if (m_ready) state_reg <= pec_pkg::ST_OUT1;
                end
                pec_pkg::ST_OUT1: begin
                    if (m_ready) state_reg <= pec_pkg::ST_IDLE;
                end
                default: state_reg <= pec_pkg::ST_IDLE;
            endcase
        end
    end

    assign m_valid     = (state_reg == pec_pkg::ST_OUT0) || (state_reg == pec_pkg::ST_OUT1);
    assign m_which     = (state_reg == pec_pkg::ST_OUT1);
    assign m_last      = m_which;
    assign m_collided  = col_reg;
    assign m_new_pos_x = m_which ? p2_reg[0] : p1_reg[0];
    assign m_new_pos_y = m_which ? p2_reg[1] : p1_reg[1];
    assign m_new_pos_z = m_which ? p2_reg[2] : p1_reg[2];
    assign m_new_vel_x = m_which ? nv_reg[1] : nv_reg[0];
    assign m_new_vel_y = m_which ? nv_reg[3] : nv_reg[2];
    assign m_new_vel_z = m_which ? nv_reg[5] : nv_reg[4];

endmodule

@@ sv/pec_divider.sv @@
// ---------------------------------------------------------------------------
// pec_divider: shared restoring divider with round half away from zero
// Divides an unsigned numerator by an unsigned divisor one bit per cycle.
// ---------------------------------------------------------------------------
module pec_divider #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic             take;
    logic [DEN_W:0]   left;

    assign shifted = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign take    = shifted >= {1'b0, den_reg};
    assign left    = {1'b0, den_reg} - rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    num_reg  <= num_reg << 1;
                    rem_reg  <= take ? shifted - {1'b0, den_reg} : shifted;
                    quot_reg <= {quot_reg[NUM_W-2:0], take};
                    cnt_reg  <= cnt_reg - 1'b1;
                end else begin
                    if (rem_reg >= left)
                        quot_reg <= quot_reg + 1'b1;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for pairwise_elastic_collision
// Drives directed and random sphere pairs with random idling on both sides.
// Each result transaction is checked against an in-bench collision predictor.
// ---------------------------------------------------------------------------
module tb;

    localparam int          W          = pec_pkg::WORD_WIDTH_DEF;
    localparam int          N_RANDOM   = 880;
    localparam int          DRAIN      = 1000;
    localparam longint      CYCLE_MAX  = 3000000;
    localparam longint      SMAX       = 64'sd2147483647;
    localparam longint      SMIN       = -64'sd2147483648;

    typedef struct {
        logic signed [W-1:0] px, py, pz, vx, vy, vz;
        logic        [W-2:0] mass, radius;
        logic                second;
    } sphere_t;

    typedef struct {
        logic [W-1:0] px, py, pz, vx, vy, vz;
        logic         collided, which, last;
    } particle_out_t;

    typedef struct {
        sphere_t s;
        bit      passthru;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [W-1:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic        [W-2:0] s_mass = '0, s_radius = '0;
    logic                s_second = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [W-1:0] m_new_pos_x, m_new_pos_y, m_new_pos_z;
    logic signed [W-1:0] m_new_vel_x, m_new_vel_y, m_new_vel_z;
    logic                m_collided, m_which, m_last;

    particle_out_t expected_particles[$];
    sphere_t       held_sphere;
    bit            holding;
    int            mismatches = 0;
    longint        cycles = 0;
    bit            s_quiet = 0, m_quiet = 0;

    always #4 aclk = ~aclk;

    pairwise_elastic_collision DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_vel_x(s_vel_x), .s_vel_y(s_vel_y), .s_vel_z(s_vel_z),
        .s_mass(s_mass), .s_radius(s_radius), .s_second(s_second),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_new_pos_x(m_new_pos_x), .m_new_pos_y(m_new_pos_y), .m_new_pos_z(m_new_pos_z),
        .m_new_vel_x(m_new_vel_x), .m_new_vel_y(m_new_vel_y), .m_new_vel_z(m_new_vel_z),
        .m_collided(m_collided), .m_which(m_which), .m_last(m_last)
    );

    function automatic logic [127:0] mag128(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [W-1:0] clamp_word(longint v);
        return (v > SMAX) ? SMAX[W-1:0] : ((v < SMIN) ? SMIN[W-1:0] : v[W-1:0]);
    endfunction

    function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
        logic [127:0] q, r;
        q = n / d;
        r = n % d;
        if (r >= d - r) q = q + 1;
        return q;
    endfunction

    function automatic logic [127:0] isqrt(logic [127:0] n);
        logic [127:0] r, t;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (n >= t * t) r = t;
        end
        return r;
    endfunction

    // elastic exchange for one axis: (va*(ma-mb) + 2*mb*vb) / (ma+mb)
    function automatic logic [W-1:0] exchange_vel(longint va, longint vb,
                                                  longint ma, longint mb);
        logic [127:0] t1, t2, m, q;
        bit           n1, n2, neg;
        t1 = mag128(va) * 128'((ma >= mb) ? ma - mb : mb - ma);
        n1 = (va < 0) != (ma < mb);
        t2 = mag128(vb) * 128'(2 * mb);
        n2 = vb < 0;
        if (n1 == n2) begin
            m = t1 + t2; neg = n1;
        end else if (t1 >= t2) begin
            m = t1 - t2; neg = n1;
        end else begin
            m = t2 - t1; neg = n2;
        end
        q = div_round(m, 128'(ma + mb));
        if (neg) return (q > 128'd2147483648) ? SMIN[W-1:0] : W'(-longint'(q[63:0]));
        return (q > 128'd2147483647) ? SMAX[W-1:0] : q[W-1:0];
    endfunction

    function automatic particle_out_t pack_particle(longint p[3], longint v[3],
                                                   bit col, bit which);
        particle_out_t r;
        r.px = p[0][W-1:0]; r.py = p[1][W-1:0]; r.pz = p[2][W-1:0];
        r.vx = v[0][W-1:0]; r.vy = v[1][W-1:0]; r.vz = v[2][W-1:0];
        r.collided = col; r.which = which; r.last = which;
        return r;
    endfunction

    task automatic resolve_collision(sphere_t s);
        longint       p1[3], v1[3], p2[3], v2[3], d[3], a[3], b[3];
        longint       m1, m2, r1, r2, dist_val, rsum, overlap, sh;
        logic [127:0] sq;
        bit           col;
        p2 = '{longint'(s.px), longint'(s.py), longint'(s.pz)};
        v2 = '{longint'(s.vx), longint'(s.vy), longint'(s.vz)};
        m2 = longint'(s.mass);
        r2 = longint'(s.radius);
        if (!s.second || !holding) begin
            held_sphere = s;
            holding = 1;
            return;
        end
        holding = 0;
        p1 = '{longint'(held_sphere.px), longint'(held_sphere.py), longint'(held_sphere.pz)};
        v1 = '{longint'(held_sphere.vx), longint'(held_sphere.vy), longint'(held_sphere.vz)};
        m1 = longint'(held_sphere.mass);
        r1 = longint'(held_sphere.radius);
        sq = 0;
        for (int c = 0; c < 3; c++) begin
            d[c] = p2[c] - p1[c];
            sq = sq + mag128(d[c]) * mag128(d[c]);
        end
        dist_val = longint'(isqrt(sq));
        rsum = r1 + r2;
        col = dist_val < rsum;
        if (col) begin
            if (m1 + m2 != 0) begin
                for (int c = 0; c < 3; c++) begin
                    a[c] = longint'(signed'(exchange_vel(v1[c], v2[c], m1, m2)));
                    b[c] = longint'(signed'(exchange_vel(v2[c], v1[c], m2, m1)));
                end
                v1 = a;
                v2 = b;
            end
            if (dist_val != 0) begin
                overlap = rsum - dist_val;
                for (int c = 0; c < 3; c++) begin
                    sh = longint'(div_round(mag128(d[c]) * 128'(overlap),
                                            128'(2 * dist_val)));
                    if (d[c] < 0) sh = -sh;
                    p1[c] = longint'(signed'(clamp_word(p1[c] - sh)));
                    p2[c] = longint'(signed'(clamp_word(p2[c] + sh)));
                end
            end
        end
        expected_particles.push_back(pack_particle(p1, v1, col, 1'b0));
        expected_particles.push_back(pack_particle(p2, v2, col, 1'b1));
    endtask

    task automatic send_sphere(sphere_t s);
        int gap;
        if ($urandom_range(0, 49) == 0) s_quiet = ~s_quiet;
        gap = s_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_pos_x  <= s.px; s_pos_y <= s.py; s_pos_z <= s.pz;
        s_vel_x  <= s.vx; s_vel_y <= s.vy; s_vel_z <= s.vz;
        s_mass   <= s.mass; s_radius <= s.radius; s_second <= s.second;
        do @(posedge aclk); while (!s_ready);
        resolve_collision(s);
    endtask

    function automatic sphere_t noise_sphere();
        sphere_t s;
        s.px = $urandom; s.py = $urandom; s.pz = $urandom;
        s.vx = $urandom; s.vy = $urandom; s.vz = $urandom;
        s.mass = (W-1)'($urandom_range(1, 32'h7fffffff));
        s.radius = (W-1)'($urandom);
        s.second = 1'($urandom_range(0, 1));
        return s;
    endfunction

    function automatic sphere_t near_sphere(sphere_t base, bit second);
        sphere_t s;
        s = noise_sphere();
        s.px = base.px + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
        s.py = base.py + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
        s.pz = base.pz + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
        s.radius = (W-1)'($urandom_range(0, 32'h18000));
        if ($urandom_range(0, 3) == 0) s.mass = (W-1)'($urandom_range(1, 32'h30000));
        s.second = second;
        return s;
    endfunction

    function automatic sphere_t sphere_at(int p, int v, int m, int r, bit second);
        sphere_t s;
        s.px = p; s.py = p; s.pz = p;
        s.vx = v; s.vy = -v; s.vz = v;
        s.mass = (W-1)'(m); s.radius = (W-1)'(r); s.second = second;
        return s;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side
    initial begin
        particle_out_t got, want;
        int gap;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 49) == 0) m_quiet = ~m_quiet;
            gap = m_quiet ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_new_pos_x, m_new_pos_y, m_new_pos_z, m_new_vel_x, m_new_vel_y,
                    m_new_vel_z, m_collided, m_which, m_last};
            if (expected_particles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %p", got);
            end else begin
                want = expected_particles.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        sphere_t   base;
        int        n_before;
        bit        typed;

        // passthru rows: far apart pair, both spheres come back unchanged
        directed = '{
            '{sphere_at(32'sh7fff0000, 32'sh10000, 32'h10000, 0, 1), 0},
            '{sphere_at(32'sh00010000, 32'sh20000, 32'h10000, 32'h100, 1), 0},
            '{sphere_at(32'sh00000000, 32'sh30000, 32'h10000, 32'h10000, 0), 0},
            '{sphere_at(32'sh40000000, 32'sh40000, 32'h20000, 32'h10000, 1), 1},
            '{sphere_at(32'sh00050000, 32'sh10000, 32'h10000, 32'h20000, 0), 0},
            '{sphere_at(32'sh00050000, -32'sh10000, 32'h30000, 32'h20000, 1), 0},
            '{sphere_at(32'sh7fffffff, 32'sh7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 0},
            '{sphere_at(32'sh7ffff000, -32'sh80000000, 1, 32'h7fffffff, 1), 0},
            '{sphere_at(-32'sh80000000, -32'sh80000000, 1, 32'h7fffffff, 0), 0},
            '{sphere_at(32'sh7fffffff, 32'sh7fffffff, 32'h7fffffff, 32'h7fffffff, 1), 0},
            '{sphere_at(-32'sh7ffff000, 32'sh7fffffff, 1, 32'h40000, 0), 0},
            '{sphere_at(-32'sh80000000, -32'sh80000000, 1, 32'h40000, 1), 0},
            '{sphere_at(32'sh00100000, 32'sh8000, 32'h10000, 0, 0), 0},
            '{sphere_at(32'sh00100000, 32'sh9000, 32'h10000, 0, 1), 0},
            '{sphere_at(32'sh00300000, 32'sh1234, 32'h7fffffff, 32'h8000, 0), 0},
            '{sphere_at(32'sh00300100, -32'sh4321, 1, 32'h8000, 1), 0},
            '{sphere_at(-32'sh10000000, 32'sh0, 32'h10000, 1, 0), 0},
            '{sphere_at(32'sh10000000, 32'sh0, 32'h10000, 1, 1), 1}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        holding = 0;

        foreach (directed[i]) begin
            typed = directed[i].passthru && holding;
            base = held_sphere;
            n_before = expected_particles.size();
            send_sphere(directed[i].s);
            if (typed) begin
                expected_particles[n_before] = '{base.px, base.py, base.pz, base.vx,
                                                 base.vy, base.vz, 1'b0, 1'b0, 1'b0};
                expected_particles[n_before + 1] = '{directed[i].s.px, directed[i].s.py,
                    directed[i].s.pz, directed[i].s.vx, directed[i].s.vy,
                    directed[i].s.vz, 1'b0, 1'b1, 1'b1};
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sphere(noise_sphere());
            end else begin
                base = noise_sphere();
                base.second = 1'b0;
                base.radius = (W-1)'($urandom_range(0, 32'h18000));
                send_sphere(base);
                send_sphere(near_sphere(base, 1'b1));
                i++;
            end
        end
        s_valid <= 1'b0;

        while (expected_particles.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/pec_pkg.sv
sv/pec_divider.sv
sv/pairwise_elastic_collision.sv
tb/sv/tb.sv
